### src/lph_pkg.sv
package lph_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int KEY_WIDTH   = 31;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int USE_W       = $clog2(TABLE_DEPTH + 1);

    // Register and field widths
    localparam int CFG_W       = 8;
    localparam int SLOT_W      = 7;
    localparam int APB_AW      = 2;
    localparam int APB_DW      = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_FIND   = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef struct packed {
        logic                 mode;
        logic [KEY_WIDTH-1:0] key;
    } t_in_item;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot;
    } t_out_item;

endpackage

### src/lph_ram.sv
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/lph_mod.sv
module lph_mod (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lph_pkg::KEY_WIDTH-1:0] i_dividend,
    input  logic [lph_pkg::USE_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [lph_pkg::USE_W-1:0]     o_rem
);

    localparam int CNT_W = $clog2(lph_pkg::KEY_WIDTH + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [lph_pkg::KEY_WIDTH-1:0] r_dvd;
    logic [lph_pkg::USE_W-1:0]     r_dvs;
    logic [lph_pkg::USE_W-1:0]     r_rem;
    logic [lph_pkg::USE_W:0]       trial;
    logic [lph_pkg::USE_W:0]       trial_sub;

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {r_rem, r_dvd[lph_pkg::KEY_WIDTH-1]};
        trial_sub = trial - {1'b0, r_dvs};
        if (trial >= {1'b0, r_dvs}) begin
            trial = trial_sub;
        end
    end

    // Control: load on start, count down one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(lph_pkg::KEY_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= trial[lph_pkg::USE_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### src/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing.
// Input channel (i_in_valid / o_in_stall) carries one transaction: mode
// (insert or find) and key. Output channel (o_out_valid / i_out_stall)
// returns one transaction per input: status and slot.
// Register table_size (APB, address 0) sets the slots in use and the hash
// modulus; 0 acts as 1, values above the depth act as the depth. Writing it
// empties the table.
// Sequence: a bit-serial modulo of the key gives the hash, then the probe walk
// steps slot by slot (an insert checks the valid bit of each slot; a find
// reads the key memory for each slot and compares that read in the following
// step, with one extra step for the last compare), then the result loads the
// output register. One item is in flight at a time.
// Reset empties the table and sets table_size to 128.
// The result sits in an output register; the next input is accepted while it
// waits. A stalled receiver holds that result, and the block stops after
// finishing the following item until the output register frees up.
module linear_probe_hash_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  lph_pkg::t_in_item              i_in_item,
    output logic                           o_in_stall,
    output logic                           o_out_valid,
    output lph_pkg::t_out_item             o_out_item,
    input  logic                           i_out_stall,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lph_pkg::APB_AW-1:0]     paddr,
    input  logic [lph_pkg::APB_DW-1:0]     pwdata,
    output logic [lph_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);

    localparam int ADDR_W = lph_pkg::ADDR_W;
    localparam int USE_W  = lph_pkg::USE_W;
    localparam int CFG_W  = lph_pkg::CFG_W;
    localparam int SLOT_W = lph_pkg::SLOT_W;
    localparam int CMP_W  = (CFG_W > USE_W) ? CFG_W : USE_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_FINISH
    } t_state;

    t_state                              r_state;
    logic [CFG_W-1:0]                    r_table_size;
    logic [lph_pkg::TABLE_DEPTH-1:0]     r_valid;
    logic                                r_mode;
    logic [lph_pkg::KEY_WIDTH-1:0]       r_key;
    logic [ADDR_W-1:0]                   r_pos;
    logic [USE_W-1:0]                    r_cnt;
    logic                                r_issued_all;
    logic                                r_p1_valid;
    logic                                r_p1_vbit;
    logic                                r_p1_last;
    logic [ADDR_W-1:0]                   r_p1_pos;
    lph_pkg::t_status                    r_res_status;
    logic [ADDR_W-1:0]                   r_res_pos;
    logic                                r_out_valid;
    lph_pkg::t_out_item                  r_out_item;

    logic                                cfg_wr;
    logic                                in_accept;
    logic                                out_free;
    logic [CMP_W-1:0]                    cfg_ext;
    logic [CMP_W-1:0]                    used_ext;
    logic [USE_W-1:0]                    used_size;
    logic [USE_W-1:0]                    pos_inc;
    logic [ADDR_W-1:0]                   pos_next;
    logic                                cnt_last;
    logic                                ram_we;
    logic [lph_pkg::KEY_WIDTH-1:0]       ram_rdata;
    logic                                find_hit;
    logic                                mod_done;
    logic [USE_W-1:0]                    mod_rem;
    logic [ADDR_W+SLOT_W-1:0]            slot_ext;

    // Configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = lph_pkg::APB_DW'(r_table_size);

    // Clamp the configured size into 1..TABLE_DEPTH
    always_comb begin
        cfg_ext = CMP_W'(r_table_size);
        if (cfg_ext == '0) begin
            used_ext = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(lph_pkg::TABLE_DEPTH)) begin
            used_ext = CMP_W'(lph_pkg::TABLE_DEPTH);
        end else begin
            used_ext = cfg_ext;
        end
        used_size = USE_W'(used_ext);
    end

    // Handshakes
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // Probe walk: step forward with wrap at the size in use
    assign pos_inc  = USE_W'(r_pos) + USE_W'(1);
    assign pos_next = (pos_inc >= used_size) ? '0 : pos_inc[ADDR_W-1:0];
    assign cnt_last = (r_cnt == used_size - USE_W'(1));

    assign ram_we   = (r_state == S_PROBE) && (r_mode == lph_pkg::MODE_INSERT)
                      && !r_valid[r_pos];
    assign find_hit = r_p1_valid && r_p1_vbit && (ram_rdata == r_key);

    lph_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_dividend (i_in_item.key),
        .i_divisor  (used_size),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    lph_ram #(
        .WIDTH (lph_pkg::KEY_WIDTH),
        .DEPTH (lph_pkg::TABLE_DEPTH)
    ) u_keys (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_key),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // Sequencer, valid bits and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_table_size <= CFG_W'(lph_pkg::TABLE_DEPTH);
            r_valid      <= '0;
            r_p1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_table_size <= pwdata[CFG_W-1:0];
                r_valid      <= '0;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_mode  <= i_in_item.mode;
                        r_key   <= i_in_item.key;
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (mod_done) begin
                        r_pos        <= mod_rem[ADDR_W-1:0];
                        r_cnt        <= '0;
                        r_issued_all <= 1'b0;
                        r_p1_valid   <= 1'b0;
                        r_state      <= S_PROBE;
                    end
                end
                S_PROBE: begin
                    if (r_mode == lph_pkg::MODE_INSERT) begin
                        // Take the first empty slot, else give up after the last
                        if (!r_valid[r_pos]) begin
                            r_valid[r_pos] <= 1'b1;
                            r_res_status   <= lph_pkg::ST_INSERTED;
                            r_res_pos      <= r_pos;
                            r_state        <= S_FINISH;
                        end else if (cnt_last) begin
                            r_res_status <= lph_pkg::ST_FULL;
                            r_res_pos    <= '0;
                            r_state      <= S_FINISH;
                        end else begin
                            r_pos <= pos_next;
                            r_cnt <= r_cnt + USE_W'(1);
                        end
                    end else begin
                        // Compare last cycle's read while issuing the next one
                        if (find_hit) begin
                            r_res_status <= lph_pkg::ST_FOUND;
                            r_res_pos    <= r_p1_pos;
                            r_p1_valid   <= 1'b0;
                            r_state      <= S_FINISH;
                        end else if (r_p1_valid && r_p1_last) begin
                            r_res_status <= lph_pkg::ST_MISSING;
                            r_res_pos    <= '0;
                            r_p1_valid   <= 1'b0;
                            r_state      <= S_FINISH;
                        end else if (!r_issued_all) begin
                            r_p1_valid   <= 1'b1;
                            r_p1_pos     <= r_pos;
                            r_p1_vbit    <= r_valid[r_pos];
                            r_p1_last    <= cnt_last;
                            r_issued_all <= cnt_last;
                            r_pos        <= pos_next;
                            r_cnt        <= r_cnt + USE_W'(1);
                        end else begin
                            r_p1_valid <= 1'b0;
                        end
                    end
                end
                S_FINISH: begin
                    // Hand the result to the output register once it frees up
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out_item.status <= r_res_status;
                        r_out_item.slot   <= slot_ext[SLOT_W-1:0];
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign slot_ext    = {{SLOT_W{1'b0}}, r_res_pos};
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An insert fills at most one slot per cycle
    a_fill_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cfg_wr |=> $countones(r_valid) <= $past($countones(r_valid)) + 1)
        else $error("more than one slot filled in a cycle");

    // A key write marks its slot as taken
    a_write_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we && !cfg_wr |=> r_valid[$past(r_pos)])
        else $error("written slot not marked valid");

    // The probe count stays inside the size in use (a find may sit one past
    // the last issue while it compares the final read)
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE |-> r_cnt <= used_size)
        else $error("probe count past table size");

    // The hash lands inside the size in use
    a_hash_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mod_done |-> mod_rem < used_size)
        else $error("hash outside table");

    // A find reports a slot that holds a valid entry
    a_found_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PROBE && r_mode == lph_pkg::MODE_FIND && find_hit
        |-> r_valid[r_p1_pos])
        else $error("found slot not valid");

endmodule
